// ----- src/cle_pkg.sv -----
// Shared definitions for the console line editor: result kinds, control
// characters, the default line length and the echo byte selection.
// No dependencies; used by cle_line_store and console_line_editor_core.
package cle_pkg;

   localparam int LINE_LENGTH_DEF = 32;

   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_CHAR = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // Echo step numbers shared by the sequencer and the byte selection.
   localparam logic [2:0] STEP_BS   = 3'd0;
   localparam logic [2:0] STEP_CHAR = 3'd1;
   localparam logic [2:0] STEP_HI   = 3'd2;
   localparam logic [2:0] STEP_LO   = 3'd3;
   localparam logic [2:0] STEP_GT   = 3'd4;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = 8'h30 + {4'h0, nib};
      end else begin
         d = 8'h37 + {4'h0, nib};
      end
      return d;
   endfunction

   // Byte shown at one step of an echo sequence. An erase walks BS, SP, BS;
   // a typed byte walks an optional BS, then itself or its bracketed hex form.
   function automatic logic [7:0] echo_byte(input logic erase, input logic hex,
                                            input logic [2:0] step,
                                            input logic [7:0] c);
      logic [7:0] b;
      if (erase) begin
         b = (step == STEP_CHAR) ? CH_SP : CH_BS;
      end else begin
         unique case (step)
            STEP_BS:   b = CH_BS;
            STEP_CHAR: b = hex ? CH_LT : c;
            STEP_HI:   b = hex_digit(c[7:4]);
            STEP_LO:   b = hex_digit(c[3:0]);
            default:   b = CH_GT;
         endcase
      end
      return b;
   endfunction

endpackage

// ----- src/console_line_editor_core.sv -----
// Top level of the console line editor: sequencer, fill count and the shared
// step counter. Depends on cle_pkg and cle_line_store.
//
//   channel | direction | ports                               | contents
//   req     | in        | req_tvalid/tready/tdata             | console byte
//   rsp     | out       | rsp_tvalid/tready/tdata/tuser/tlast | echo, line chars, line end
//   csr     | in        | csr_we/csr_wdata                    | echo enable
//
// One word is taken in a cycle when the block is idle; the next word is taken
// once every result of the previous one has been delivered, so a word with
// results holds the input until its last result word has been accepted.
// A line end gives fill_count + 1 result words whether or not echo is on; with
// echo on an erase of a non-empty line gives three and a typed byte one to five,
// with echo off neither gives any. Each line character and echo byte is paced
// by one step of the shared step counter and its stop compare, one word per
// cycle while rsp_tready is high. A word with no result leaves the block idle.
// Reset is synchronous and clears the sequencer, fill count and echo enable;
// the line store needs no clearing. A stalled result simply holds.
module console_line_editor_core #(
   parameter int LINE_LENGTH = cle_pkg::LINE_LENGTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast,   // last
   input  logic       csr_we,
   input  logic       csr_wdata    // echo_enable
);

   localparam int AW = $clog2(LINE_LENGTH);
   localparam int CW = (AW > 3) ? AW : 3;
   localparam logic [AW-1:0] FILL_MAX = AW'(LINE_LENGTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LINE = 4'b0010,
      ST_END  = 4'b0100,
      ST_ECHO = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cnt_ff, cnt_in;     // shared step counter
   logic [CW-1:0] stop_ff, stop_in;   // step at which the sequence ends
   logic          echo_ff;
   logic          erase_ff, erase_in;
   logic          hex_ff, hex_in;
   logic [7:0]    char_ff, char_in;

   logic          req_acc, rsp_acc, at_stop;
   logic          is_eol, is_erase, printable, overflow;
   logic          st_wr_en;
   logic [7:0]    st_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // The stop compare of the sequencer, shared by line readout and echo steps.
   assign at_stop = (cnt_ff == stop_ff);

   assign is_eol    = (req_tdata == cle_pkg::CH_CR) || (req_tdata == cle_pkg::CH_LF);
   assign is_erase  = (req_tdata == cle_pkg::CH_BS) || (req_tdata == cle_pkg::CH_DEL);
   assign printable = (req_tdata >= cle_pkg::CH_SP) && (req_tdata <= cle_pkg::CH_TILDE);
   assign overflow  = (fill_ff >= FILL_MAX);

   // A typed byte lands in the store only while the line has room; once full,
   // it is not written and the line stays the same.
   assign st_wr_en = req_acc && !is_eol && !is_erase && !overflow;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      cnt_in   = cnt_ff;
      stop_in  = stop_ff;
      erase_in = erase_ff;
      hex_in   = hex_ff;
      char_in  = char_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               char_in = req_tdata;
               priority if (is_eol) begin
                  // The line is streamed out whether or not echo is on.
                  fill_in = '0;
                  cnt_in  = '0;
                  stop_in = CW'(fill_ff - AW'(1));
                  if (fill_ff == '0) begin
                     state_in = ST_END;
                  end else begin
                     state_in = ST_LINE;
                  end
               end else if (is_erase) begin
                  if (fill_ff != '0) begin
                     fill_in  = fill_ff - AW'(1);
                     erase_in = 1'b1;
                     hex_in   = 1'b0;
                     cnt_in   = CW'(cle_pkg::STEP_BS);
                     stop_in  = CW'(cle_pkg::STEP_HI);
                     if (echo_ff) begin
                        state_in = ST_ECHO;
                     end
                  end
               end else begin
                  if (!overflow) begin
                     fill_in = fill_ff + AW'(1);
                  end
                  erase_in = 1'b0;
                  hex_in   = !printable;
                  // An overflowing byte's echo opens with a backspace.
                  cnt_in   = overflow ? CW'(cle_pkg::STEP_BS) : CW'(cle_pkg::STEP_CHAR);
                  stop_in  = printable ? CW'(cle_pkg::STEP_CHAR) : CW'(cle_pkg::STEP_GT);
                  if (echo_ff) begin
                     state_in = ST_ECHO;
                  end
               end
            end
         end
         ST_LINE: begin
            if (rsp_acc) begin
               if (at_stop) begin
                  state_in = ST_END;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         ST_END: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         ST_ECHO: begin
            if (rsp_acc) begin
               if (at_stop) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         echo_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (csr_we) begin
            echo_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      stop_ff  <= stop_in;
      erase_ff <= erase_in;
      hex_ff   <= hex_in;
      char_ff  <= char_in;
   end

   // The store is read at the next counter value, so its registered output
   // always holds the character at the current step during line readout.
   cle_line_store #(
      .LINE_LENGTH (LINE_LENGTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_tdata),
      .rd_addr (cnt_in[AW-1:0]),
      .rd_data (st_rd_data)
   );

   always_comb begin
      rsp_tvalid = 1'b0;
      rsp_tdata  = 8'h00;
      rsp_tuser  = cle_pkg::KIND_ECHO;
      rsp_tlast  = 1'b0;
      unique case (state_ff)
         ST_LINE: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = st_rd_data;
            rsp_tuser  = cle_pkg::KIND_CHAR;
         end
         ST_END: begin
            rsp_tvalid = 1'b1;
            rsp_tuser  = cle_pkg::KIND_END;
            rsp_tlast  = 1'b1;
         end
         ST_ECHO: begin
            rsp_tvalid = 1'b1;
            rsp_tdata  = cle_pkg::echo_byte(erase_ff, hex_ff, cnt_ff[2:0], char_ff);
            rsp_tuser  = cle_pkg::KIND_ECHO;
            rsp_tlast  = at_stop;
         end
         default: begin
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   // After the final word of an input has gone, the block is free again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block not idle after last result word");

   // A line end always yields at least its marker word.
   a_eol_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata == cle_pkg::CH_CR || req_tdata == cle_pkg::CH_LF)
      |=> rsp_tvalid)
      else $error("line end produced no result");

   // The held line never exceeds its capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond line capacity");

   // The step counter never runs past the stop step during readout.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINE || state_ff == ST_ECHO) |-> cnt_ff <= stop_ff)
      else $error("step counter passed its stop value");

endmodule

// ----- src/cle_line_store.sv -----
// Line store of the console line editor: one write port, one registered
// read port. Depends on cle_pkg for its default depth.
module cle_line_store #(
   parameter int LINE_LENGTH = cle_pkg::LINE_LENGTH_DEF,
   parameter int AW          = $clog2(LINE_LENGTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [LINE_LENGTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
